@@ sv/lzss_fbd_pkg.sv @@
package lzss_fbd_pkg;

    localparam int unsigned HISTORY_DEPTH = 4096;
    localparam int unsigned HIST_AW       = $clog2(HISTORY_DEPTH);
    localparam int unsigned LIMIT_W       = 21;
    localparam logic [LIMIT_W-1:0] DEFAULT_LIMIT = LIMIT_W'(1048576);
    localparam int unsigned TOKENS_PER_FLAG = 8;
    localparam int unsigned LEN_BIAS      = 3;
    localparam int unsigned LEN_W         = 5;

    localparam int unsigned CMD_QUEUE_DEPTH    = 4;
    localparam int unsigned RESULT_QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DIST = 2'd1,
        ST_LIMIT    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_LITERAL = 2'd1,
        CMD_MATCH   = 2'd2,
        CMD_TERM    = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        logic [7:0] data_in;
        logic       stream_start;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       stream_end;
        status_t    status;
    } out_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [7:0]         lit;
        logic [HIST_AW-1:0] offset;
        logic [LEN_W-1:0]   len;
    } cmd_t;

endpackage

@@ sv/lzss_fbd_ram.sv @@
module lzss_fbd_ram
    import lzss_fbd_pkg::*;
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = HISTORY_DEPTH
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/lzss_fbd_fifo.sv @@
module lzss_fbd_fifo
    import lzss_fbd_pkg::*;
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = CMD_QUEUE_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    output logic [WIDTH-1:0]         rd_data,
    output logic                     full,
    output logic                     empty,
    output logic [$clog2(DEPTH):0]   count
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + (AW+1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ sv/lzss_fbd_front.sv @@
module lzss_fbd_front
    import lzss_fbd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  in_t  item,
    output logic cmd_push,
    output cmd_t cmd,
    input  logic cmd_full
);

    typedef enum logic [1:0] {
        PH_FLAG     = 2'd0,
        PH_TOKEN    = 2'd1,
        PH_MATCH_HI = 2'd2
    } phase_t;

    phase_t     phase_reg, phase_next, ph;
    logic [7:0] flag_reg, flag_next;
    logic [3:0] tokens_reg, tokens_next, tokens_dec;
    logic [7:0] low_reg, low_next;
    logic       accept;

    assign full       = cmd_full;
    assign accept     = push && !cmd_full;
    assign ph         = item.stream_start ? PH_FLAG : phase_reg;
    assign tokens_dec = (tokens_reg != 4'd0) ? tokens_reg - 4'd1 : 4'd0;

    always_comb
    begin
        phase_next  = phase_reg;
        flag_next   = flag_reg;
        tokens_next = tokens_reg;
        low_next    = low_reg;
        cmd_push    = 1'b0;
        cmd.kind    = CMD_CLEAR;
        cmd.lit     = item.data_in;
        cmd.offset  = {item.data_in[3:0], low_reg};
        cmd.len     = LEN_W'(item.data_in[7:4]) + LEN_W'(LEN_BIAS);
        if (accept)
        begin
            // a start byte is always a flag byte, so the clear is its only command
            if (item.stream_start)
            begin
                cmd_push = 1'b1;
                cmd.kind = CMD_CLEAR;
            end
            unique case (ph)
                PH_FLAG:
                begin
                    flag_next   = item.data_in;
                    tokens_next = 4'(TOKENS_PER_FLAG);
                    phase_next  = PH_TOKEN;
                end
                PH_TOKEN:
                begin
                    if (flag_reg[0])
                    begin
                        cmd_push    = 1'b1;
                        cmd.kind    = CMD_LITERAL;
                        flag_next   = flag_reg >> 1;
                        tokens_next = tokens_dec;
                        phase_next  = (tokens_dec == 4'd0) ? PH_FLAG : PH_TOKEN;
                    end
                    else
                    begin
                        low_next   = item.data_in;
                        phase_next = PH_MATCH_HI;
                    end
                end
                PH_MATCH_HI:
                begin
                    cmd_push = 1'b1;
                    if (low_reg == 8'd0 && item.data_in == 8'd0)
                    begin
                        // the back end drops everything after this until a restart
                        cmd.kind = CMD_TERM;
                    end
                    else
                    begin
                        cmd.kind    = CMD_MATCH;
                        flag_next   = flag_reg >> 1;
                        tokens_next = tokens_dec;
                        phase_next  = (tokens_dec == 4'd0) ? PH_FLAG : PH_TOKEN;
                    end
                end
                default:
                begin
                    phase_next = PH_FLAG;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FLAG;
            flag_reg   <= '0;
            tokens_reg <= '0;
            low_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            flag_reg   <= flag_next;
            tokens_reg <= tokens_next;
            low_reg    <= low_next;
        end
    end

endmodule

@@ sv/lzss_fbd_back.sv @@
module lzss_fbd_back
    import lzss_fbd_pkg::*;
#(
    parameter int unsigned RES_DEPTH = RESULT_QUEUE_DEPTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cmd_t                       cmd,
    input  logic                       cmd_empty,
    output logic                       cmd_pop,
    input  logic [LIMIT_W-1:0]         limit,
    input  logic [$clog2(RES_DEPTH):0] res_count,
    output logic                       res_push,
    output out_t                       res
);

    typedef enum logic {
        S_IDLE = 1'b0,
        S_COPY = 1'b1
    } state_t;

    state_t             state_reg, state_next;
    logic [LIMIT_W-1:0] bp_reg, bp_next, bp_plus1;
    logic               finished_reg, finished_next;
    logic [LEN_W-1:0]   remain_reg, remain_next;
    logic               b_valid_reg, b_valid_next;
    logic               b_notice_reg, b_notice_next;
    status_t            b_status_reg, b_status_next;
    logic               b_from_ram_reg, b_from_ram_next;
    logic               b_bypass_reg, b_bypass_next;
    logic               b_last_reg, b_last_next;
    logic [7:0]         b_lit_reg, b_lit_next;
    logic [7:0]         last_byte_reg, last_byte_next;
    logic [HIST_AW-1:0] src_reg, src_next;
    logic               dist1_reg, dist1_next;

    logic [7:0]         ram_rdata;
    logic               ram_we;
    logic [7:0]         b_byte;
    logic               hit;
    logic               room_idle, room_copy;

    lzss_fbd_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (bp_reg[HIST_AW-1:0]),
        .wdata (b_byte),
        .raddr (src_reg),
        .rdata (ram_rdata)
    );

    assign bp_plus1  = bp_reg + LIMIT_W'(1);
    assign hit       = (bp_plus1 >= limit);
    assign room_idle = (32'(res_count) < 32'(RES_DEPTH));
    assign room_copy = ((32'(res_count) + 32'(b_valid_reg)) < 32'(RES_DEPTH));
    // distance one repeats the most recently produced byte, not the RAM read
    assign b_byte    = b_bypass_reg   ? last_byte_reg :
                       b_from_ram_reg ? ram_rdata     : b_lit_reg;

    always_comb
    begin
        state_next      = state_reg;
        bp_next         = bp_reg;
        finished_next   = finished_reg;
        remain_next     = remain_reg;
        b_valid_next    = 1'b0;
        b_notice_next   = b_notice_reg;
        b_status_next   = b_status_reg;
        b_from_ram_next = b_from_ram_reg;
        b_bypass_next   = b_bypass_reg;
        b_last_next     = b_last_reg;
        b_lit_next      = b_lit_reg;
        last_byte_next  = last_byte_reg;
        src_next        = src_reg;
        dist1_next      = dist1_reg;
        cmd_pop         = 1'b0;
        ram_we          = 1'b0;
        res_push        = 1'b0;
        res.out_byte    = b_byte;
        res.byte_valid  = 1'b1;
        res.run_last    = b_last_reg || hit;
        res.stream_end  = hit;
        res.status      = hit ? ST_LIMIT : ST_OK;

        // result stage, a byte or end notice in flight is dropped once finished
        if (b_valid_reg && !finished_reg)
        begin
            res_push = 1'b1;
            if (b_notice_reg)
            begin
                res.out_byte   = 8'd0;
                res.byte_valid = 1'b0;
                res.run_last   = 1'b1;
                res.stream_end = 1'b1;
                res.status     = b_status_reg;
                finished_next  = 1'b1;
            end
            else
            begin
                ram_we         = 1'b1;
                bp_next        = bp_plus1;
                last_byte_next = b_byte;
                finished_next  = hit;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                // commands start only with the result stage drained
                if (!cmd_empty && !b_valid_reg && room_idle)
                begin
                    cmd_pop         = 1'b1;
                    b_from_ram_next = 1'b0;
                    b_bypass_next   = 1'b0;
                    b_last_next     = 1'b1;
                    b_lit_next      = cmd.lit;
                    b_notice_next   = 1'b0;
                    b_status_next   = ST_OK;
                    if (cmd.kind == CMD_CLEAR)
                    begin
                        bp_next       = '0;
                        finished_next = 1'b0;
                    end
                    else if (!finished_reg)
                    begin
                        case (cmd.kind)
                            CMD_LITERAL:
                            begin
                                b_valid_next = 1'b1;
                            end
                            CMD_TERM:
                            begin
                                b_valid_next  = 1'b1;
                                b_notice_next = 1'b1;
                            end
                            CMD_MATCH:
                            begin
                                if (cmd.offset == '0 || LIMIT_W'(cmd.offset) > bp_reg)
                                begin
                                    b_valid_next  = 1'b1;
                                    b_notice_next = 1'b1;
                                    b_status_next = ST_BAD_DIST;
                                end
                                else
                                begin
                                    state_next  = S_COPY;
                                    src_next    = bp_reg[HIST_AW-1:0] - cmd.offset;
                                    remain_next = cmd.len;
                                    dist1_next  = (cmd.offset == HIST_AW'(1));
                                end
                            end
                            default:
                            begin
                                b_valid_next = 1'b0;
                            end
                        endcase
                    end
                end
            end
            S_COPY:
            begin
                if (finished_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (room_copy)
                begin
                    // read issued from src_reg this cycle, data lands in the result stage
                    b_valid_next    = 1'b1;
                    b_notice_next   = 1'b0;
                    b_from_ram_next = 1'b1;
                    b_bypass_next   = dist1_reg;
                    b_last_next     = (remain_reg == LEN_W'(1));
                    src_next        = src_reg + HIST_AW'(1);
                    remain_next     = remain_reg - LEN_W'(1);
                    if (remain_reg == LEN_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            bp_reg       <= '0;
            finished_reg <= 1'b0;
            remain_reg   <= '0;
            b_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            bp_reg       <= bp_next;
            finished_reg <= finished_next;
            remain_reg   <= remain_next;
            b_valid_reg  <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_notice_reg   <= b_notice_next;
        b_status_reg   <= b_status_next;
        b_from_ram_reg <= b_from_ram_next;
        b_bypass_reg   <= b_bypass_next;
        b_last_reg     <= b_last_next;
        b_lit_reg      <= b_lit_next;
        last_byte_reg  <= last_byte_next;
        src_reg        <= src_next;
        dist1_reg      <= dist1_next;
    end

endmodule

@@ sv/lzss_flag_byte_decompressor.sv @@
// LZSS decompressor for the flag-byte format with a 12-bit distance and a 4-bit
// length: feed it payload bytes after the 16-byte header, marking the first one
// with stream_start, and pop decompressed bytes from the result queue. A front
// parser takes one input byte per cycle while its command queue has room; flag
// bytes and the low byte of a match cost nothing further. The back end runs the
// commands against a 4096-byte history RAM and takes no new command before the
// last is through; a match of up to 18 bytes, from one two-byte token, comes out
// one byte per cycle from the RAM's read port while the result queue has room.
// Write out_limit while idle; zero or anything above 1048576 selects 1048576. After
// an end notice or the limit byte, input is dropped until the next stream_start.
module lzss_flag_byte_decompressor
    import lzss_fbd_pkg::*;
#(
    parameter int unsigned CMD_DEPTH = CMD_QUEUE_DEPTH,
    parameter int unsigned RES_DEPTH = RESULT_QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  in_t                item,
    output logic               empty,
    input  logic               pop,
    output out_t               result,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_data
);

    logic [LIMIT_W-1:0]         out_limit_reg;
    logic [LIMIT_W-1:0]         limit;
    logic                       f_cmd_push;
    cmd_t                       f_cmd;
    logic                       cmd_full;
    logic                       cmd_empty;
    logic                       cmd_pop;
    cmd_t                       q_cmd;
    logic                       res_push;
    out_t                       res;
    logic [$clog2(RES_DEPTH):0] res_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_limit_reg <= '0;
        end
        else if (cfg_we)
        begin
            out_limit_reg <= cfg_data;
        end
    end

    assign limit = (out_limit_reg == '0 || out_limit_reg > DEFAULT_LIMIT) ?
                   DEFAULT_LIMIT : out_limit_reg;

    lzss_fbd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .cmd_push (f_cmd_push),
        .cmd      (f_cmd),
        .cmd_full (cmd_full)
    );

    lzss_fbd_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_cmd_push),
        .wr_data (f_cmd),
        .rd_en   (cmd_pop),
        .rd_data (q_cmd),
        .full    (cmd_full),
        .empty   (cmd_empty),
        .count   ()
    );

    lzss_fbd_back #(
        .RES_DEPTH (RES_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .limit     (limit),
        .res_count (res_count),
        .res_push  (res_push),
        .res       (res)
    );

    // the back end only issues work with room reserved, so full never stops a transfer
    lzss_fbd_fifo #(
        .WIDTH ($bits(out_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res),
        .rd_en   (pop),
        .rd_data (result),
        .full    (),
        .empty   (empty),
        .count   (res_count)
    );

endmodule

@@ dv/lzss_flag_byte_decompressor_tb.sv @@
module lzss_flag_byte_decompressor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lzss_fbd_pkg::*;

    localparam int unsigned CYCLE_LIMIT       = 2_000_000;
    localparam int unsigned SETTLE_CYCLES     = 100;
    localparam int unsigned LONG_HOLD         = 400;
    localparam int unsigned SHORT_PHASE_ITEMS = 20;
    localparam int unsigned SHORT_PHASES      = 7;
    localparam int unsigned RING_TARGET       = HISTORY_DEPTH + 300;
    localparam int unsigned MAX_SHOWN         = 10;

    typedef enum logic [1:0] {
        DEC_FLAG,
        DEC_TOKEN,
        DEC_MATCH_HI
    } dec_phase_t;

    typedef struct packed {
        logic               set_lim;
        logic [LIMIT_W-1:0] lim;
        logic [7:0]         data;
        logic               start;
        logic               chk;
        out_t               want;
    } dir_row_t;

    localparam int DIR_ROWS = 28;
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{1'b1, 21'd0, 8'h00, 1'b0, 1'b0, '0},
        // decoding right after reset, no start mark
        '{1'b0, 21'd0, 8'h00, 1'b0, 1'b0, '0},
        '{1'b0, 21'd0, 8'h01, 1'b0, 1'b0, '0},
        '{1'b0, 21'd0, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, ST_BAD_DIST}},
        '{1'b0, 21'd0, 8'h55, 1'b0, 1'b0, '0},
        // literal, overlapping 18-byte match, six literals
        '{1'b0, 21'd0, 8'hFD, 1'b1, 1'b0, '0},
        '{1'b0, 21'd0, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0, ST_OK}},
        '{1'b0, 21'd0, 8'h01, 1'b0, 1'b0, '0},
        '{1'b0, 21'd0, 8'hF0, 1'b0, 1'b0, '0},
        '{1'b0, 21'd0, 8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0, ST_OK}},
        '{1'b0, 21'd0, 8'h80, 1'b0, 1'b1, '{8'h80, 1'b1, 1'b1, 1'b0, ST_OK}},
        '{1'b0, 21'd0, 8'h7F, 1'b0, 1'b1, '{8'h7F, 1'b1, 1'b1, 1'b0, ST_OK}},
        '{1'b0, 21'd0, 8'h01, 1'b0, 1'b1, '{8'h01, 1'b1, 1'b1, 1'b0, ST_OK}},
        '{1'b0, 21'd0, 8'hAA, 1'b0, 1'b1, '{8'hAA, 1'b1, 1'b1, 1'b0, ST_OK}},
        '{1'b0, 21'd0, 8'h55, 1'b0, 1'b1, '{8'h55, 1'b1, 1'b1, 1'b0, ST_OK}},
        // terminator pair
        '{1'b0, 21'd0, 8'h00, 1'b0, 1'b0, '0},
        '{1'b0, 21'd0, 8'h00, 1'b0, 1'b0, '0},
        '{1'b0, 21'd0, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, ST_OK}},
        // zero distance
        '{1'b0, 21'd0, 8'h00, 1'b1, 1'b0, '0},
        '{1'b0, 21'd0, 8'h00, 1'b0, 1'b0, '0},
        '{1'b0, 21'd0, 8'h10, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, ST_BAD_DIST}},
        // largest distance on an empty history
        '{1'b0, 21'd0, 8'h00, 1'b1, 1'b0, '0},
        '{1'b0, 21'd0, 8'hFF, 1'b0, 1'b0, '0},
        '{1'b0, 21'd0, 8'hFF, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, ST_BAD_DIST}},
        // limit of one byte
        '{1'b1, 21'd1, 8'h00, 1'b0, 1'b0, '0},
        '{1'b0, 21'd0, 8'hFF, 1'b1, 1'b0, '0},
        '{1'b0, 21'd0, 8'h12, 1'b0, 1'b1, '{8'h12, 1'b1, 1'b1, 1'b1, ST_LIMIT}},
        '{1'b0, 21'd0, 8'h34, 1'b0, 1'b0, '0}
    };

    logic               clk;
    logic               rst_n = 1'b0;
    logic               push;
    logic               full;
    in_t                item;
    logic               empty;
    logic               pop = 1'b0;
    out_t               result;
    logic               cfg_we;
    logic [LIMIT_W-1:0] cfg_data;

    // decoder copy
    logic [LIMIT_W-1:0] limit_reg;
    dec_phase_t         dec_phase;
    logic [7:0]         dec_flags;
    logic [3:0]         dec_tokens;
    logic [7:0]         dec_match_lo;
    logic [LIMIT_W-1:0] dec_count;
    logic               dec_done;
    logic [7:0]         dec_hist [HISTORY_DEPTH];

    out_t        step_results [$];
    out_t        pending [$];
    int unsigned n_err = 0;
    logic [7:0]  gen_hi = 8'h00;
    bit          no_idle = 1'b0;
    bit          long_hold_req = 1'b0;
    bit          hold_taken = 1'b0;
    int unsigned rx_wait = 0;

    lzss_flag_byte_decompressor u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic out_t make_res(logic [7:0] b, logic valid, logic fin, status_t st);
        out_t r;
        r.out_byte   = b;
        r.byte_valid = valid;
        r.run_last   = 1'b0;
        r.stream_end = fin;
        r.status     = st;
        return r;
    endfunction

    function automatic void clear_decoder();
        dec_phase    = DEC_FLAG;
        dec_flags    = 8'h00;
        dec_tokens   = 4'd0;
        dec_match_lo = 8'h00;
        dec_count    = '0;
        dec_done     = 1'b0;
    endfunction

    function automatic void put_byte(logic [7:0] b);
        logic [LIMIT_W-1:0] lim;
        lim = (limit_reg == '0 || limit_reg > DEFAULT_LIMIT) ? DEFAULT_LIMIT : limit_reg;
        dec_hist[dec_count[HIST_AW-1:0]] = b;
        dec_count = dec_count + 1'b1;
        if (dec_count >= lim)
        begin
            dec_done = 1'b1;
            step_results = {step_results, make_res(b, 1'b1, 1'b1, ST_LIMIT)};
        end
        else
        begin
            step_results = {step_results, make_res(b, 1'b1, 1'b0, ST_OK)};
        end
    endfunction

    function automatic void next_token();
        dec_flags = dec_flags >> 1;
        if (dec_tokens != 0)
            dec_tokens = dec_tokens - 1'b1;
        dec_phase = (dec_tokens == 0) ? DEC_FLAG : DEC_TOKEN;
    endfunction

    // results caused by one accepted input byte, appended to step_results
    function automatic void decode_byte(in_t it);
        logic [HIST_AW-1:0] offs;
        logic [LIMIT_W-1:0] src;
        int unsigned        len;
        out_t               tail;
        if (it.stream_start)
            clear_decoder();
        if (dec_done)
            return;
        case (dec_phase)
            DEC_TOKEN:
            begin
                if (dec_flags[0])
                begin
                    put_byte(it.data_in);
                    next_token();
                end
                else
                begin
                    dec_match_lo = it.data_in;
                    dec_phase    = DEC_MATCH_HI;
                end
            end
            DEC_MATCH_HI:
            begin
                offs = {it.data_in[3:0], dec_match_lo};
                len  = it.data_in[7:4] + LEN_BIAS;
                if (dec_match_lo == 8'h00 && it.data_in == 8'h00)
                begin
                    dec_done = 1'b1;
                    step_results = {step_results, make_res(8'h00, 1'b0, 1'b1, ST_OK)};
                end
                else if (offs == '0 || LIMIT_W'(offs) > dec_count)
                begin
                    dec_done = 1'b1;
                    step_results = {step_results, make_res(8'h00, 1'b0, 1'b1, ST_BAD_DIST)};
                end
                else
                begin
                    for (int k = 0; k < len && !dec_done; k++)
                    begin
                        src = dec_count - LIMIT_W'(offs);
                        put_byte(dec_hist[src[HIST_AW-1:0]]);
                    end
                    next_token();
                end
            end
            default:
            begin
                dec_flags  = it.data_in;
                dec_tokens = 4'(TOKENS_PER_FLAG);
                dec_phase  = DEC_TOKEN;
            end
        endcase
        if (step_results.size() != 0)
        begin
            tail = step_results[step_results.size()-1];
            tail.run_last = 1'b1;
            step_results[step_results.size()-1] = tail;
        end
    endfunction

    // mostly well-formed streams: matches point into written history
    function automatic in_t next_input(bit ring);
        in_t         it;
        logic [11:0] d;
        int unsigned r;
        int unsigned span;
        it.stream_start = 1'b0;
        it.data_in      = 8'($urandom);
        r = $urandom_range(99);
        if (dec_done)
        begin
            it.stream_start = ring || r < 85;
            if (ring)
                it.data_in = 8'hFF;
            return it;
        end
        if (!ring && r < 2)
        begin
            it.stream_start = 1'b1;
            return it;
        end
        case (dec_phase)
            DEC_FLAG:
            begin
                if (ring)
                    it.data_in = ($urandom_range(3) == 0) ? 8'h01 : 8'h00;
            end
            DEC_TOKEN:
            begin
                if (!dec_flags[0])
                begin
                    span = (dec_count > LIMIT_W'(4095)) ? 4095 : int'(dec_count);
                    if (span != 0 && (ring || r < 90))
                    begin
                        d = 12'($urandom_range(span, 1));
                        it.data_in = d[7:0];
                        gen_hi = {ring ? 4'hF : 4'($urandom), d[11:8]};
                    end
                    else if (r < 94)
                    begin
                        it.data_in = 8'h00;
                        gen_hi     = 8'h00;
                    end
                    else
                    begin
                        gen_hi = 8'($urandom);
                    end
                end
            end
            default:
                it.data_in = gen_hi;
        endcase
        return it;
    endfunction

    task automatic send(in_t it, logic chk, out_t want);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
        step_results.delete();
        decode_byte(it);
        if (chk)
            pending = {pending, want};
        else
            pending = {pending, step_results};
    endtask

    // only while idle: drain, then let the back end finish silent work
    task automatic write_limit(logic [LIMIT_W-1:0] v);
        push <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        limit_reg = v;
    endtask

    initial
    begin : stimulus
        in_t                it;
        int unsigned        n_items;
        logic [LIMIT_W-1:0] lim;
        bit                 ignored;
        push     <= 1'b0;
        item     <= '0;
        cfg_we   <= 1'b0;
        cfg_data <= '0;
        limit_reg = '0;
        clear_decoder();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (DIR_TAB[i].set_lim)
            begin
                write_limit(DIR_TAB[i].lim);
            end
            else
            begin
                it.data_in      = DIR_TAB[i].data;
                it.stream_start = DIR_TAB[i].start;
                send(it, DIR_TAB[i].chk, DIR_TAB[i].want);
            end
        end

        // one long stream of long matches so the history ring wraps
        write_limit('1);
        no_idle = 1'b1;
        do
        begin
            send(next_input(1'b1), 1'b0, '0);
            if (dec_count > LIMIT_W'(2000))
                no_idle = 1'b0;
        end
        while (dec_count < LIMIT_W'(RING_TARGET));

        for (int p = 0; p < SHORT_PHASES; p++)
        begin
            case (p)
                0: lim = LIMIT_W'($urandom_range(600, 41));
                1: lim = LIMIT_W'(2);
                2: lim = LIMIT_W'($urandom_range(40, 3));
                3: lim = DEFAULT_LIMIT;
                4: lim = DEFAULT_LIMIT + 1'b1;
                5: lim = LIMIT_W'($urandom);
                default: lim = '0;
            endcase
            write_limit(lim);
            // receiver stalls while items keep coming, so the block backs up
            if (p == 0)
                long_hold_req = 1'b1;
            n_items = 0;
            while (n_items < SHORT_PHASE_ITEMS)
            begin
                it = next_input(1'b0);
                ignored = dec_done && !it.stream_start;
                send(it, 1'b0, '0);
                if (!ignored)
                    n_items++;
            end
        end

        push <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (n_err == 0 && pending.size() == 0)
            $display("lzss_flag_byte_decompressor_tb passed");
        else
            $display("lzss_flag_byte_decompressor_tb failed");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop        <= 1'b0;
            rx_wait    <= 0;
            hold_taken <= 1'b0;
        end
        else if (long_hold_req && !hold_taken)
        begin
            pop        <= 1'b0;
            rx_wait    <= LONG_HOLD;
            hold_taken <= 1'b1;
        end
        else if (rx_wait != 0)
        begin
            pop     <= 1'b0;
            rx_wait <= rx_wait - 1;
        end
        else
        begin
            pop     <= 1'b1;
            rx_wait <= pick_gap();
        end
    end

    // one result transfer per edge at most
    always @(posedge clk)
    begin : check_results
        out_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending.size() == 0)
            begin
                n_err++;
                if (n_err <= MAX_SHOWN)
                    $display("unexpected result: byte %02h valid %b last %b end %b status %0d",
                             result.out_byte, result.byte_valid, result.run_last,
                             result.stream_end, result.status);
            end
            else
            begin
                want = pending.pop_front();
                if (result.out_byte !== want.out_byte || result.byte_valid !== want.byte_valid
                    || result.run_last !== want.run_last
                    || result.stream_end !== want.stream_end
                    || result.status !== want.status)
                begin
                    n_err++;
                    if (n_err <= MAX_SHOWN)
                    begin
                        $display("mismatch: expected byte %02h valid %b last %b end %b status %0d",
                                 want.out_byte, want.byte_valid, want.run_last,
                                 want.stream_end, want.status);
                        $display("          got      byte %02h valid %b last %b end %b status %0d",
                                 result.out_byte, result.byte_valid, result.run_last,
                                 result.stream_end, result.status);
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("lzss_flag_byte_decompressor_tb failed");
        $finish;
    end

endmodule
